### hdl/h264_slice_type_extractor_assert.svh
// Assertion macros for the checker of the slice type extractor.
`ifndef H264_SLICE_TYPE_EXTRACTOR_ASSERT_SVH
`define H264_SLICE_TYPE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STE_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("slice type extractor: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("slice type extractor: assertion failed");

`endif

### hdl/h264ste_pkg.sv
// Package for the slice type extractor: types, codes and constants.
package h264ste_pkg;

	localparam int unsigned TYPE_W = 3;
	localparam int unsigned LZ_W   = 6;
	localparam int unsigned CV_W   = 3;

	localparam logic [TYPE_W-1:0] TYPE_UNKNOWN      = 3'd5;
	localparam logic [LZ_W-1:0]   MAX_LEADING_ZEROS = 6'd31;
	localparam logic [4:0]        NAL_SLICE         = 5'd1;
	localparam logic [4:0]        NAL_IDR           = 5'd5;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_HEADER = 3'b010,
		PH_CODES  = 3'b100
	} phase_t;

	// Exp-Golomb walker state; only the low suffix bits matter for mapping
	typedef struct packed {
		logic            code_index;
		logic [LZ_W-1:0] lz;
		logic [LZ_W-1:0] sbl;
		logic [CV_W-1:0] cv;
	} code_st_t;

endpackage

### hdl/h264_slice_type_extractor.sv
// Top level of the H.264 Annex B slice type extractor.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  input    | data_valid / data_stall    | data_byte, last_byte
//  result   | slice_valid / slice_stall  | slice_type
//  config   | cfg_valid / cfg_ready      | stop_after_first
//
// One byte per cycle sustained, save for a byte that makes a result while the
// output register is full and stalled. A byte sits in the input register, where
// its eight bits are walked through the Exp-Golomb decoder, then its result (if
// any) lands in the output register. Bytes that make no result keep flowing
// while a result waits on slice_stall; a byte that makes a result holds in the
// input register until the output register frees. arst_n clears all parse
// state and the stop flag; cfg_ready is always high.
module h264_slice_type_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       slice_valid,
	input  logic       slice_stall,
	output logic [h264ste_pkg::TYPE_W-1:0] slice_type,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       stop_after_first
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parse state
	h264ste_pkg::phase_t   phase_q, phase_d;
	logic [1:0]            zero_run_q, zero_run_d;
	h264ste_pkg::code_st_t code_q, code_d;
	logic                  found_q, found_d;
	logic                  stop_q;

	// output register
	logic                            slice_valid_q;
	logic [h264ste_pkg::TYPE_W-1:0]  slice_type_q;

	// bit walker temporaries
	h264ste_pkg::code_st_t          walk;
	logic                           walk_done;
	logic                           walk_fin;
	logic                           walk_bit;
	logic [h264ste_pkg::TYPE_W-1:0] walk_res;

	logic                           emit;
	logic                           adv;
	logic                           is_start;

	// slice_type code value to class: 0..4 and 5..9 fold onto P,B,I,SP,SI; any other value gives TYPE_UNKNOWN
	function automatic logic [h264ste_pkg::TYPE_W-1:0] map_type(
		input logic [h264ste_pkg::LZ_W-1:0] lz,
		input logic [h264ste_pkg::CV_W-1:0] cv
	);
		logic [3:0] v;
		logic [h264ste_pkg::TYPE_W-1:0] r;
		v = ((4'd1 << lz[1:0]) - 4'd1) + {1'b0, cv};
		if (lz >= 6'd4 || v >= 4'd10) begin
			r = h264ste_pkg::TYPE_UNKNOWN;
		end else if (v >= 4'd5) begin
			r = 3'(v - 4'd5);
		end else begin
			r = v[2:0];
		end
		return r;
	endfunction

	// Walk the eight bits of the held byte, MSB first; stop at a result.
	always_comb begin
		walk      = code_q;
		walk_done = 1'b0;
		walk_res  = '0;
		walk_fin  = 1'b0;
		walk_bit  = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!walk_done) begin
				walk_bit = byte_s1[3'(i)];
				walk_fin = 1'b0;
				if (walk.sbl == '0) begin
					if (!walk_bit) begin
						walk.lz = walk.lz + 6'd1;
						if (walk.lz > h264ste_pkg::MAX_LEADING_ZEROS) begin
							walk_done = 1'b1;
							walk_res  = h264ste_pkg::TYPE_UNKNOWN;
						end
					end else if (walk.lz == '0) begin
						walk_fin = 1'b1;
					end else begin
						walk.sbl = walk.lz;
						walk.cv  = '0;
					end
				end else begin
					walk.cv  = {walk.cv[1:0], walk_bit};
					walk.sbl = walk.sbl - 6'd1;
					if (walk.sbl == '0) begin
						walk_fin = 1'b1;
					end
				end
				if (walk_fin) begin
					if (!walk.code_index) begin
						// first_mb_in_slice done, move on to slice_type
						walk.code_index = 1'b1;
						walk.lz         = '0;
						walk.sbl        = '0;
						walk.cv         = '0;
					end else begin
						walk_done = 1'b1;
						walk_res  = map_type(walk.lz, walk.cv);
					end
				end
			end
		end
	end

	assign is_start = (byte_s1 == 8'd1) && (zero_run_q >= 2'd2);

	// Per-byte next state
	always_comb begin
		phase_d    = phase_q;
		zero_run_d = zero_run_q;
		code_d     = code_q;
		found_d    = found_q;
		emit       = 1'b0;
		if (valid_s1 && !(found_q && stop_q)) begin
			if (phase_q == h264ste_pkg::PH_HEADER) begin
				if (byte_s1[4:0] == h264ste_pkg::NAL_SLICE ||
				    byte_s1[4:0] == h264ste_pkg::NAL_IDR) begin
					phase_d = h264ste_pkg::PH_CODES;
					code_d  = '0;
				end else begin
					phase_d = h264ste_pkg::PH_SEARCH;
				end
			end else if (is_start) begin
				// also aborts a code parse in progress
				phase_d = h264ste_pkg::PH_HEADER;
				code_d  = '0;
			end else if (phase_q == h264ste_pkg::PH_CODES) begin
				if (walk_done) begin
					emit    = 1'b1;
					found_d = 1'b1;
					phase_d = h264ste_pkg::PH_SEARCH;
					code_d  = '0;
				end else begin
					code_d = walk;
				end
			end else begin
				phase_d = h264ste_pkg::PH_SEARCH;
			end
			if (byte_s1 == 8'd0) begin
				zero_run_d = (zero_run_q == 2'd3) ? 2'd3 : zero_run_q + 2'd1;
			end else begin
				zero_run_d = 2'd0;
			end
		end
		if (valid_s1 && last_s1) begin
			// buffer end: everything back to reset, stop flag kept
			phase_d    = h264ste_pkg::PH_SEARCH;
			zero_run_d = 2'd0;
			code_d     = '0;
			found_d    = 1'b0;
		end
	end

	assign adv        = valid_s1 && (!emit || !slice_valid_q || !slice_stall);
	assign data_stall = valid_s1 && !adv;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= h264ste_pkg::PH_SEARCH;
			zero_run_q <= 2'd0;
			code_q     <= '0;
			found_q    <= 1'b0;
		end else if (adv) begin
			phase_q    <= phase_d;
			zero_run_q <= zero_run_d;
			code_q     <= code_d;
			found_q    <= found_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			stop_q <= stop_after_first;
		end
	end

	// Output register: refilled in the same cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_valid_q <= 1'b0;
		end else if (adv && emit) begin
			slice_valid_q <= 1'b1;
		end else if (!slice_stall) begin
			slice_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			slice_type_q <= walk_res;
		end
	end

	assign slice_valid = slice_valid_q;
	assign slice_type  = slice_type_q;

endmodule

### hdl/h264ste_checker.sv
// Port-level checker for the slice type extractor, bound to the top level.
`include "h264_slice_type_extractor_assert.svh"

module h264ste_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_stall,
	input logic [7:0] data_byte,
	input logic       last_byte,
	input logic       slice_valid,
	input logic       slice_stall,
	input logic [h264ste_pkg::TYPE_W-1:0] slice_type,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       stop_after_first
);

	logic data_xfer;
	logic unused_ok;

	assign data_xfer = data_valid && !data_stall;
	assign unused_ok = ^{data_byte, last_byte, cfg_valid, cfg_ready, stop_after_first};

	`STE_ASSERT_IMPL(a_type_range, clk, arst_n, slice_valid || unused_ok === 1'bx, slice_type <= h264ste_pkg::TYPE_UNKNOWN || !slice_valid)
	`STE_ASSERT_NEXT(a_hold, clk, arst_n, slice_valid && slice_stall, slice_valid && $stable(slice_type))
	`STE_ASSERT_IMPL(a_rise_src, clk, arst_n, $rose(slice_valid), $past(data_xfer, 2))
	`STE_ASSERT_IMPL(a_stall_cause, clk, arst_n, data_stall, slice_valid && slice_stall)

endmodule

bind h264_slice_type_extractor h264ste_checker u_h264ste_checker (.*);

### bench/h264_slice_type_extractor_check.sv
`timescale 1ns / 100ps
// Checker for the slice type extractor: tracks the stream, predicts slice types, compares results.
module h264_slice_type_extractor_check
	import h264ste_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              data_valid,
	input  logic              data_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              slice_valid,
	input  logic              slice_stall,
	input  logic [TYPE_W-1:0] slice_type,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              stop_after_first,
	output int                errors,
	output int                pending,
	output int                checked
);

	// shadow of the parser
	logic              stop_first;
	logic [1:0]        zrun;
	phase_t            phase;
	logic              in_type;	// 0: first_mb_in_slice, 1: slice_type
	logic [LZ_W-1:0]   lz;
	logic [LZ_W-1:0]   sfx_left;
	logic [31:0]       cv;
	logic              got_one;
	logic [TYPE_W-1:0] types_due[$];
	logic [TYPE_W-1:0] want;

	task automatic restart_code();
		lz = '0;
		sfx_left = '0;
		cv = '0;
	endtask

	task automatic clear_parse();
		zrun = '0;
		phase = PH_SEARCH;
		in_type = 1'b0;
		got_one = 1'b0;
		restart_code();
	endtask

	// one byte through the parser; a finished slice_type code queues its class, an overlong prefix queues unknown
	task automatic parse_byte(input logic [7:0] b, input logic lb);
		logic              is_start;
		logic              done;
		logic              fin;
		logic [31:0]       v;
		logic [TYPE_W-1:0] ty;
		done = 1'b0;
		ty = TYPE_UNKNOWN;
		if (!(got_one && stop_first)) begin
			is_start = (b == 8'h01) && (zrun >= 2'd2);
			if (phase == PH_HEADER) begin
				// header byte is taken even if it is 00 or 01
				phase = (b[4:0] == NAL_SLICE || b[4:0] == NAL_IDR) ? PH_CODES : PH_SEARCH;
				in_type = 1'b0;
				restart_code();
			end else if (is_start) begin
				// also aborts a code parse in progress
				phase = PH_HEADER;
				in_type = 1'b0;
				restart_code();
			end else if (phase == PH_CODES) begin
				for (int i = 7; i >= 0; i--) begin
					if (!done) begin
						fin = 1'b0;
						if (sfx_left == '0) begin
							if (!b[i]) begin
								lz = lz + 6'd1;
								if (lz > MAX_LEADING_ZEROS)
									done = 1'b1;	// overlong prefix: unknown
							end else if (lz == '0) begin
								fin = 1'b1;
							end else begin
								sfx_left = lz;
								cv = '0;
							end
						end else begin
							cv = {cv[30:0], b[i]};
							sfx_left = sfx_left - 6'd1;
							fin = (sfx_left == '0);
						end
						if (fin) begin
							if (!in_type) begin
								in_type = 1'b1;
								restart_code();
							end else begin
								done = 1'b1;
								v = ((32'd1 << lz) - 32'd1) + cv;
								ty = (lz >= 4 || v >= 10) ? TYPE_UNKNOWN : TYPE_W'(v % 5);
							end
						end
					end
				end
				// rest of the byte is dropped once a result is out
				if (done) begin
					got_one = 1'b1;
					phase = PH_SEARCH;
					in_type = 1'b0;
					restart_code();
					types_due.insert(types_due.size(), ty);
				end
			end else begin
				phase = PH_SEARCH;
			end
			zrun = (b != 8'h00) ? 2'd0 : ((zrun == 2'd3) ? 2'd3 : zrun + 2'd1);
		end
		// end of buffer: parse state back to reset, register kept
		if (lb)
			clear_parse();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_first = 1'b0;
			clear_parse();
			types_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				stop_first = stop_after_first;
			if (slice_valid && !slice_stall) begin
				if (types_due.size() == 0) begin
					$error("slice_type: expected none, actual %0d", slice_type);
					errors++;
				end else begin
					want = types_due.pop_front();
					checked++;
					if (slice_type !== want) begin
						$error("slice_type: expected %0d, actual %0d", want, slice_type);
						errors++;
					end
				end
			end
			if (data_valid && !data_stall)
				parse_byte(data_byte, last_byte);
			pending = types_due.size();
		end
	end

endmodule

### bench/h264_slice_type_extractor_test.sv
`timescale 1ns / 100ps
// Testbench top for the slice type extractor: stimulus, idling, verdict.
module h264_slice_type_extractor_test;
	import h264ste_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              data_valid;
	logic              data_stall;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              slice_valid;
	logic              slice_stall;
	logic [TYPE_W-1:0] slice_type;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              stop_after_first;

	int errors;
	int pending;
	int checked;

	// stimulus bookkeeping
	int   n_bytes = 0;
	int   n_bufs = 0;
	bit   idle_on = 1'b1;	// cleared for the last part of the run
	bit   quiet = 1'b0;	// sender idles nowhere within the current item
	bit   rx_calm = 1'b0;	// receiver stretch without stalls
	logic [7:0] nal_q[$];	// bytes of the item being built
	bit   bit_q[$];		// bit string of Exp-Golomb codes before packing

	always #2 clk = ~clk;

	h264_slice_type_extractor u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_valid       (data_valid),
		.data_stall       (data_stall),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.slice_valid      (slice_valid),
		.slice_stall      (slice_stall),
		.slice_type       (slice_type),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.stop_after_first (stop_after_first)
	);

	h264_slice_type_extractor_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_valid       (data_valid),
		.data_stall       (data_stall),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.slice_valid      (slice_valid),
		.slice_stall      (slice_stall),
		.slice_type       (slice_type),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.stop_after_first (stop_after_first),
		.errors           (errors),
		.pending          (pending),
		.checked          (checked)
	);

	// Receiver: random stall bursts, with calm stretches in between.
	initial begin
		slice_stall = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_calm = ~rx_calm;
			if (idle_on && !rx_calm && $urandom_range(0, 7) == 0) begin
				slice_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			slice_stall <= 1'b0;
		end
	end

	// Hard stop; far beyond the slowest legal run (every byte behind a full
	// sender gap and a full result stall).
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// One byte transfer. Entered and left at a rising edge; an idle burst may
	// come first. Stall is sampled as it stood at the edge.
	task automatic send_byte(input logic [7:0] b, input logic lb);
		if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lb;
		@(posedge clk);
		while (data_stall) @(posedge clk);
		n_bytes++;
		if (lb)
			n_bufs++;
	endtask

	task automatic send_buf(input bit end_buf);
		foreach (nal_q[i])
			send_byte(nal_q[i], end_buf && i == nal_q.size() - 1);
		nal_q.delete();
	endtask

	// Sender holds off until every predicted slice type has come out.
	// pending is read on the falling edge, clear of the checker's update.
	task automatic wait_empty();
		data_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Idle point for a register write: bytes that make no result may still be
	// in the two-stage pipe, so wait on after that for them to leave it.
	task automatic drain();
		wait_empty();
		repeat (8) @(posedge clk);
	endtask

	task automatic set_stop(input logic v);
		cfg_valid <= 1'b1;
		stop_after_first <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_start();
		repeat ($urandom_range(2, 4)) nal_q.insert(nal_q.size(), 8'h00);
		nal_q.insert(nal_q.size(), 8'h01);
	endtask

	// Exp-Golomb code with the given prefix length and a random suffix.
	// A prefix of 32 or more zeros is the overlong case.
	task automatic push_code(input int zeros);
		repeat (zeros) bit_q.insert(bit_q.size(), 1'b0);
		bit_q.insert(bit_q.size(), 1'b1);
		repeat (zeros) bit_q.insert(bit_q.size(), 1'($urandom_range(0, 1)));
	endtask

	// Pad with random bits to a byte boundary, then move bytes MSB first.
	task automatic pack_bits();
		logic [7:0] b;
		while (bit_q.size() % 8 != 0) bit_q.insert(bit_q.size(), 1'($urandom_range(0, 1)));
		while (bit_q.size() != 0) begin
			for (int i = 7; i >= 0; i--)
				b[i] = bit_q.pop_front();
			nal_q.insert(nal_q.size(), b);
		end
	endtask

	// Start code, slice NAL header, first_mb_in_slice, slice_type, some tail.
	// Mostly short codes; now and then long ones up to 31 prefix zeros, or an overlong one of 32..36 when asked.
	task automatic gen_slice(input bit overlong);
		int mb_zeros;
		int st_zeros;
		mb_zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 31) : $urandom_range(0, 6);
		st_zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
		if (overlong) begin
			if ($urandom_range(0, 1))
				mb_zeros = $urandom_range(32, 36);
			else
				st_zeros = $urandom_range(32, 36);
		end
		push_start();
		nal_q.insert(nal_q.size(), {3'($urandom_range(0, 7)),
			$urandom_range(0, 1) ? NAL_SLICE : NAL_IDR});
		push_code(mb_zeros);
		push_code(st_zeros);
		pack_bits();
		repeat ($urandom_range(0, 2)) nal_q.insert(nal_q.size(), 8'($urandom));
	endtask

	// One random stretch of stream: mostly well-formed slice headers, the rest
	// slices with an overlong code, other NAL units, noise, and slices cut off
	// (by buffer end or by the next start code).
	task automatic gen_item();
		int         kind;
		int         cut;
		bit         end_buf;
		logic [7:0] hdr;
		kind = $urandom_range(0, 99);
		quiet = ($urandom_range(0, 3) == 0);
		end_buf = ($urandom_range(0, 5) == 0);
		if (kind < 60) begin
			gen_slice(1'b0);
		end else if (kind < 68) begin
			gen_slice(1'b1);
		end else if (kind < 78) begin
			push_start();
			do hdr = 8'($urandom); while (hdr[4:0] == NAL_SLICE || hdr[4:0] == NAL_IDR);
			nal_q.insert(nal_q.size(), hdr);
			repeat ($urandom_range(1, 6)) nal_q.insert(nal_q.size(), 8'($urandom));
		end else if (kind < 88) begin
			// zero-heavy noise so stray start codes turn up
			repeat ($urandom_range(1, 8))
				nal_q.insert(nal_q.size(),
					($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
		end else begin
			gen_slice(1'b0);
			cut = $urandom_range(4, nal_q.size() - 1);
			nal_q = nal_q[0:cut-1];
			if (kind >= 94)
				end_buf = 1'b1;	// code cut short by the buffer end
		end
		send_buf(end_buf);
	endtask

	task automatic run_random(input int n);
		int target;
		target = n_bytes + n;
		while (n_bytes < target) begin
			gen_item();
			if ($urandom_range(0, 39) == 0)
				wait_empty();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		stop_after_first = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, register at reset value:
		//  - header 65 (IDR), FF: both codes '1' -> P, rest of byte dropped
		//  - four-byte start code (run saturates), header 41, A0 -> B
		//  - header 25 then 32 zero bits -> unknown at once
		//  - 01 ends that run as a start code; header 00 is non-slice but
		//    feeds the zero run, so 00 01 right after is a start code again
		//  - header 65, B7 -> I, on the last byte of the buffer
		nal_q = '{8'h00, 8'h00, 8'h01, 8'h65, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'hA0,
			8'h00, 8'h00, 8'h01, 8'h25, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h01, 8'h00, 8'h00, 8'h01, 8'h65, 8'hB7};
		send_buf(1'b1);
		drain();

		// Stop after first: two slices in one buffer give a single P
		set_stop(1'b1);
		nal_q = '{8'h00, 8'h00, 8'h01, 8'h65, 8'hC0,
			8'h00, 8'h00, 8'h01, 8'h65, 8'hC0};
		send_buf(1'b1);
		run_random(250);
		drain();

		set_stop(1'b0);
		run_random(300);
		drain();

		set_stop(1'b1);
		run_random(100);
		drain();

		// Last part: full rate on both sides
		set_stop(1'b0);
		idle_on = 1'b0;
		run_random(150);
		drain();

		$display("Streamed %0d bytes in %0d buffers; %0d slice types checked.",
			n_bytes, n_bufs, checked);
		$display("stop_after_first set and cleared; both sides idled in bursts, then full rate.");
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
